FILE: hdl/three_key_debounce_event_queue_assert.svh
// assertion macros used by the event queue rtl
// no dependencies; expects clock and reset signals in the including scope
`ifndef THREE_KEY_DEBOUNCE_EVENT_QUEUE_ASSERT_SVH
`define THREE_KEY_DEBOUNCE_EVENT_QUEUE_ASSERT_SVH

// checked on every rising clock edge outside reset
`define TKDEQ_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// checked on every rising clock edge, reset included
`define TKDEQ_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

FILE: hdl/tkdeq_pkg.sv
// shared types and constants for the three key debounce event queue
// no dependencies
`timescale 1ns / 1ps

package tkdeq_pkg;

   localparam int NUM_KEYS       = 3;
   localparam int COUNT_W        = 8;
   localparam int KEY_W          = 2;
   localparam int QUEUE_DEPTH    = 64;
   localparam int QPTR_W         = $clog2(QUEUE_DEPTH);
   localparam int NUM_BANKS      = 4;
   localparam int BANK_SEL_W     = $clog2(NUM_BANKS);
   localparam int BANK_DEPTH     = QUEUE_DEPTH / NUM_BANKS;
   localparam int BANK_AW        = (BANK_DEPTH > 1) ? $clog2(BANK_DEPTH) : 1;
   localparam int CSR_AW         = 3;
   localparam int CSR_DW         = 32;
   localparam logic [COUNT_W-1:0] DEBOUNCE_RESET = 8'd10;

   typedef enum logic [KEY_W-1:0] {
      EVT_NONE   = 2'd0,
      EVT_LEFT   = 2'd1,
      EVT_MIDDLE = 2'd2,
      EVT_RIGHT  = 2'd3
   } key_code_type;

   typedef enum logic [0:0] {
      REG_DEBOUNCE_TICKS = 1'b0
   } csr_index_type;

   typedef logic [NUM_KEYS-1:0] key_push_type;

   function automatic key_code_type key_code(input int idx);
      key_code_type code;
      case (idx)
         0: code = EVT_LEFT;
         1: code = EVT_MIDDLE;
         2: code = EVT_RIGHT;
         default: code = EVT_NONE;
      endcase
      return code;
   endfunction

endpackage

FILE: hdl/tkdeq_req_if.sv
// scan tick channel: three key pin levels per transfer
// depends on tkdeq_pkg
`timescale 1ns / 1ps

interface tkdeq_req_if import tkdeq_pkg::*; ();
   logic valid;
   logic ready;
   logic left_level;
   logic middle_level;
   logic right_level;

   modport source (output valid, output left_level, output middle_level,
                   output right_level, input ready);
   modport sink (input valid, input left_level, input middle_level,
                 input right_level, output ready);
endinterface

FILE: hdl/tkdeq_rsp_if.sv
// key event channel: one popped key code per transfer
// depends on tkdeq_pkg
`timescale 1ns / 1ps

interface tkdeq_rsp_if import tkdeq_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [KEY_W-1:0] key_event;

   modport source (output valid, output key_event, input ready);
   modport sink (input valid, input key_event, output ready);
endinterface

FILE: hdl/tkdeq_ram.sv
// generic single write port ram with registered read
// no dependencies
`timescale 1ns / 1ps

module tkdeq_ram #(
   parameter int WIDTH = 2,
   parameter int DEPTH = 16,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: hdl/tkdeq_key.sv
// one key debouncer: press/release phase bit and match counter
// depends on tkdeq_pkg
`timescale 1ns / 1ps

module tkdeq_key import tkdeq_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               advance,
   input  logic               level,
   input  logic [COUNT_W-1:0] debounce_ticks,
   output logic               push
);

   logic               phase_ff, phase_in;
   logic [COUNT_W-1:0] count_ff, count_in;
   logic [COUNT_W:0]   count_inc;
   logic               match;
   logic               reach;

   always_comb begin
      match     = (level == phase_ff);
      count_inc = {1'b0, count_ff} + {{COUNT_W{1'b0}}, 1'b1};
      reach     = (count_inc >= {1'b0, debounce_ticks});
      push      = match && reach && phase_ff;
      phase_in  = phase_ff;
      count_in  = count_ff;
      if (advance) begin
         if (!match) begin
            count_in = '0;
         end else if (reach) begin
            count_in = '0;
            phase_in = !phase_ff;
         end else begin
            count_in = count_inc[COUNT_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= 1'b0;
         count_ff <= '0;
      end else begin
         phase_ff <= phase_in;
         count_ff <= count_in;
      end
   end

endmodule

FILE: hdl/tkdeq_queue.sv
// event ring queue: four interleaved banks take up to three pushes, then one pop
// depends on tkdeq_pkg, tkdeq_ram and the assertion macro header
`timescale 1ns / 1ps

`include "three_key_debounce_event_queue_assert.svh"

module tkdeq_queue import tkdeq_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             advance,
   input  key_push_type     push,
   output logic [KEY_W-1:0] key_event
);

   logic [QPTR_W-1:0]  rp_ff, rp_in;
   logic [QPTR_W-1:0]  wp_ff, wp_in;
   logic               pop_ff, pop_in;
   logic               byp_ff, byp_in;
   key_code_type       byp_code_ff, byp_code_in;
   logic [BANK_SEL_W-1:0] bank_sel_ff, bank_sel_in;

   logic [QPTR_W-1:0]  slot_addr [NUM_KEYS];
   logic [QPTR_W-1:0]  wp_next;
   logic               empty;
   logic               byp_hit;
   key_code_type       byp_code;

   logic [NUM_BANKS-1:0] bank_we;
   logic [BANK_AW-1:0]   bank_waddr [NUM_BANKS];
   logic [KEY_W-1:0]     bank_wdata [NUM_BANKS];
   logic [BANK_AW-1:0]   bank_raddr;
   logic [KEY_W-1:0]     bank_rdata [NUM_BANKS];

   // slot positions of the pushes in key order, bypass of a same-cycle write
   always_comb begin
      logic [1:0] offset;
      offset   = 2'd0;
      byp_hit  = 1'b0;
      byp_code = EVT_NONE;
      for (int k = 0; k < NUM_KEYS; k++) begin
         slot_addr[k] = wp_ff + QPTR_W'(offset);
         if (advance && push[k] && (slot_addr[k] == rp_ff)) begin
            byp_hit  = 1'b1;
            byp_code = key_code(k);
         end
         if (push[k]) begin
            offset = offset + 2'd1;
         end
      end
      wp_next = wp_ff + QPTR_W'(offset);
      empty   = (rp_ff == wp_next);
   end

   always_comb begin
      for (int b = 0; b < NUM_BANKS; b++) begin
         bank_we[b]    = 1'b0;
         bank_waddr[b] = '0;
         bank_wdata[b] = EVT_NONE;
         for (int k = 0; k < NUM_KEYS; k++) begin
            if (advance && push[k] &&
                (slot_addr[k][BANK_SEL_W-1:0] == BANK_SEL_W'(b))) begin
               bank_we[b]    = 1'b1;
               bank_waddr[b] = BANK_AW'(slot_addr[k] >> BANK_SEL_W);
               bank_wdata[b] = key_code(k);
            end
         end
      end
      bank_raddr = BANK_AW'(rp_ff >> BANK_SEL_W);
   end

   for (genvar b = 0; b < NUM_BANKS; b++) begin : g_bank
      tkdeq_ram #(
         .WIDTH (KEY_W),
         .DEPTH (BANK_DEPTH)
      ) u_bank (
         .clock   (clock),
         .wr_en   (bank_we[b]),
         .wr_addr (bank_waddr[b]),
         .wr_data (bank_wdata[b]),
         .rd_en   (advance),
         .rd_addr (bank_raddr),
         .rd_data (bank_rdata[b])
      );
   end

   always_comb begin
      rp_in       = rp_ff;
      wp_in       = wp_ff;
      pop_in      = pop_ff;
      byp_in      = byp_ff;
      byp_code_in = byp_code_ff;
      bank_sel_in = bank_sel_ff;
      if (advance) begin
         wp_in       = wp_next;
         pop_in      = !empty;
         byp_in      = byp_hit;
         byp_code_in = byp_code;
         bank_sel_in = rp_ff[BANK_SEL_W-1:0];
         if (!empty) begin
            rp_in = rp_ff + QPTR_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rp_ff  <= '0;
         wp_ff  <= '0;
         pop_ff <= 1'b0;
         byp_ff <= 1'b0;
      end else begin
         rp_ff  <= rp_in;
         wp_ff  <= wp_in;
         pop_ff <= pop_in;
         byp_ff <= byp_in;
      end
      byp_code_ff <= byp_code_in;
      bank_sel_ff <= bank_sel_in;
   end

   always_comb begin
      if (!pop_ff) begin
         key_event = EVT_NONE;
      end else if (byp_ff) begin
         key_event = byp_code_ff;
      end else begin
         key_event = bank_rdata[bank_sel_ff];
      end
   end

   `TKDEQ_ASSERT(a_one_write_per_push,
      advance |-> ($countones(bank_we) == $countones(push)),
      "queue bank writes do not match the pushes")
   `TKDEQ_ASSERT(a_bypass_implies_pop,
      (advance && byp_hit) |-> !empty,
      "same-cycle bypass while queue looks empty")
   `TKDEQ_ASSERT(a_ptrs_hold_when_idle,
      !advance |=> ($stable(rp_ff) && $stable(wp_ff)),
      "queue pointers moved without a transfer")

endmodule

FILE: hdl/tkdeq_csr.sv
// apb-style register port holding the debounce threshold
// depends on tkdeq_pkg
`timescale 1ns / 1ps

module tkdeq_csr import tkdeq_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               psel,
   input  logic               penable,
   input  logic               pwrite,
   input  logic [CSR_AW-1:0]  paddr,
   input  logic [CSR_DW-1:0]  pwdata,
   output logic [CSR_DW-1:0]  prdata,
   output logic               pready,
   output logic [COUNT_W-1:0] debounce_ticks
);

   logic [COUNT_W-1:0] ticks_ff, ticks_in;
   csr_index_type      reg_index;
   logic               wr_hit;

   always_comb begin
      reg_index = csr_index_type'(paddr[CSR_AW-1]);
      wr_hit    = psel && penable && pwrite;
      ticks_in  = ticks_ff;
      prdata    = '0;
      case (reg_index)
         REG_DEBOUNCE_TICKS: begin
            prdata = CSR_DW'(ticks_ff);
            if (wr_hit) begin
               ticks_in = pwdata[COUNT_W-1:0];
            end
         end
         default: begin
            prdata = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ticks_ff <= DEBOUNCE_RESET;
      end else begin
         ticks_ff <= ticks_in;
      end
   end

   assign pready         = 1'b1;
   assign debounce_ticks = ticks_ff;

endmodule

FILE: hdl/three_key_debounce_event_queue.sv
// Three key debouncer with a 64 entry event queue. Each transfer on the
// request channel is one scan tick; it yields exactly one response transfer
// carrying the popped key code (0 when the queue is empty). The block takes one
// scan tick per clock: an input register feeds the per-key counters and a queue
// built from four interleaved banks, so up to three pushes and one pop finish
// in the same cycle, and the popped code is registered in the queue before the
// response carries it. A stalled response holds the pipeline; no reset sweep is needed.
// Pushes never check for a full queue: overflow makes it look empty.
// depends on tkdeq_pkg, the channel interfaces, tkdeq_key, tkdeq_queue, tkdeq_csr
`timescale 1ns / 1ps

module three_key_debounce_event_queue import tkdeq_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   tkdeq_req_if.sink          req_bus,
   tkdeq_rsp_if.source        rsp_bus,
   input  logic               psel,
   input  logic               penable,
   input  logic               pwrite,
   input  logic [CSR_AW-1:0]  paddr,
   input  logic [CSR_DW-1:0]  pwdata,
   output logic [CSR_DW-1:0]  prdata,
   output logic               pready
);

   logic                 in_valid_ff, in_valid_in;
   logic [NUM_KEYS-1:0]  levels_ff, levels_in;
   logic                 out_valid_ff, out_valid_in;
   logic                 advance;
   logic                 req_xfer;
   key_push_type         push;
   logic [COUNT_W-1:0]   debounce_ticks;

   always_comb begin
      advance       = in_valid_ff && (!out_valid_ff || rsp_bus.ready);
      req_bus.ready = !in_valid_ff || advance;
      req_xfer      = req_bus.valid && req_bus.ready;
      in_valid_in   = req_xfer ? 1'b1 : (advance ? 1'b0 : in_valid_ff);
      levels_in     = req_xfer ?
                      {req_bus.right_level, req_bus.middle_level, req_bus.left_level} :
                      levels_ff;
      out_valid_in  = advance ? 1'b1 : (rsp_bus.ready ? 1'b0 : out_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
      levels_ff <= levels_in;
   end

   tkdeq_csr u_csr (
      .clock          (clock),
      .reset          (reset),
      .psel           (psel),
      .penable        (penable),
      .pwrite         (pwrite),
      .paddr          (paddr),
      .pwdata         (pwdata),
      .prdata         (prdata),
      .pready         (pready),
      .debounce_ticks (debounce_ticks)
   );

   for (genvar k = 0; k < NUM_KEYS; k++) begin : g_key
      tkdeq_key u_key (
         .clock          (clock),
         .reset          (reset),
         .advance        (advance),
         .level          (levels_ff[k]),
         .debounce_ticks (debounce_ticks),
         .push           (push[k])
      );
   end

   tkdeq_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .push      (push),
      .key_event (rsp_bus.key_event)
   );

   assign rsp_bus.valid = out_valid_ff;

endmodule
